### src/mlt_pkg.sv
// mlt_pkg: shared types, codes and constants of the mutex lock table.
// Used by mlt_ctrl, mlt_datapath and mutex_lock_table; depends on nothing.
package mlt_pkg;

  // Default sizes of the bank.
  localparam int NUM_LOCKS_DEF    = 16;
  localparam int COUNTER_BITS_DEF = 11;
  localparam int TID_BITS_DEF     = 16;

  // Field widths of a transaction.
  localparam int OP_W     = 3;
  localparam int INDEX_W  = 4;
  localparam int THREAD_W = 16;
  localparam int MTYPE_W  = 2;
  localparam int STATUS_W = 3;

  // The lock index field reaches this many entries at most.
  localparam int ADDR_LOCKS = 16;

  // Layout of the lock word.
  localparam int                 WORD_W      = 16;
  localparam int                 CNT_FIELD_W = 11;
  localparam int                 CNT_LSB     = 2;
  localparam int                 SHARED_BIT  = 13;
  localparam logic [WORD_W-1:0]  CNT_ONE     = 16'h0004;
  localparam logic [WORD_W-1:0]  W_DESTROYED = 16'hffff;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INIT    = 3'd0;
  localparam logic [OP_W-1:0] OP_LOCK    = 3'd1;
  localparam logic [OP_W-1:0] OP_TRYLOCK = 3'd2;
  localparam logic [OP_W-1:0] OP_UNLOCK  = 3'd3;
  localparam logic [OP_W-1:0] OP_DESTROY = 3'd4;

  // Status codes of a result.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WAIT      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DEADLOCK  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd5;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd6;

  // Lock type codes, held in the top two bits of the lock word.
  localparam logic [MTYPE_W-1:0] LT_NORMAL     = 2'd0;
  localparam logic [MTYPE_W-1:0] LT_RECURSIVE  = 2'd1;
  localparam logic [MTYPE_W-1:0] LT_ERRORCHECK = 2'd2;
  localparam logic [MTYPE_W-1:0] LT_DEAD       = 2'd3;

  // Lock state codes, held in the low two bits of the lock word.
  localparam logic [1:0] LS_UNLOCKED  = 2'd0;
  localparam logic [1:0] LS_LOCKED    = 2'd1;
  localparam logic [1:0] LS_CONTENDED = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_e;

  // How the datapath forms the new lock word.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_NORM_STATE,
    WR_STATE,
    WR_CNT_INC,
    WR_CNT_DEC,
    WR_DESTROY
  } word_wr_e;

  // How the datapath forms the new owner.
  typedef enum logic [1:0] {
    OWN_KEEP,
    OWN_SET,
    OWN_CLEAR
  } owner_wr_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                done;
    word_wr_e            word_wr;
    owner_wr_e           owner_wr;
    logic [1:0]          set_state;
    logic [STATUS_W-1:0] status;
    logic                wake;
  } cmd_t;

  // Status of the latched transaction and its lock entry.
  typedef struct packed {
    logic               in_range;
    logic [OP_W-1:0]    op;
    logic               init_bad;
    logic [MTYPE_W-1:0] lk_type;
    logic [1:0]         lk_state;
    logic               owner_match;
    logic               cnt_full;
    logic               cnt_zero;
  } lock_stat_t;

endpackage

### src/mlt_ctrl.sv
// mlt_ctrl: controller of the mutex lock table; decides each operation.
// Depends on mlt_pkg; drives mlt_datapath through mlt_pkg::cmd_t.
module mlt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  mlt_pkg::lock_stat_t stat_i,
  output logic                busy,
  output mlt_pkg::cmd_t       cmd_o
);

  mlt_pkg::ctrl_state_e state_q, state_d;
  logic                 blocking;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mlt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mlt_pkg::S_IDLE: begin
        if (start) begin
          state_d = mlt_pkg::S_EXEC;
        end
      end
      mlt_pkg::S_EXEC: begin
        state_d = mlt_pkg::S_IDLE;
      end
      default: begin
        state_d = mlt_pkg::S_IDLE;
      end
    endcase
  end

  assign blocking = (stat_i.op == mlt_pkg::OP_LOCK);

  always_comb begin
    cmd_o           = '0;
    cmd_o.word_wr   = mlt_pkg::WR_NONE;
    cmd_o.owner_wr  = mlt_pkg::OWN_KEEP;
    cmd_o.status    = mlt_pkg::ST_INVALID;
    busy            = 1'b0;
    unique case (state_q)
      mlt_pkg::S_IDLE: begin
        cmd_o.load = start;
      end
      mlt_pkg::S_EXEC: begin
        busy       = 1'b1;
        cmd_o.done = 1'b1;
        if (stat_i.in_range) begin
          unique case (stat_i.op) inside
            mlt_pkg::OP_INIT: begin
              cmd_o.word_wr  = mlt_pkg::WR_INIT;
              cmd_o.owner_wr = mlt_pkg::OWN_CLEAR;
              cmd_o.status   = stat_i.init_bad ? mlt_pkg::ST_INVALID : mlt_pkg::ST_OK;
            end
            mlt_pkg::OP_LOCK, mlt_pkg::OP_TRYLOCK: begin
              if (stat_i.lk_type == mlt_pkg::LT_DEAD) begin
                cmd_o.status = mlt_pkg::ST_INVALID;
              end else if (stat_i.lk_type == mlt_pkg::LT_NORMAL) begin
                // Normal locks ignore the owner entirely.
                if (stat_i.lk_state == mlt_pkg::LS_UNLOCKED) begin
                  cmd_o.word_wr   = mlt_pkg::WR_NORM_STATE;
                  cmd_o.set_state = mlt_pkg::LS_LOCKED;
                  cmd_o.status    = mlt_pkg::ST_OK;
                end else if (!blocking) begin
                  cmd_o.status = mlt_pkg::ST_BUSY;
                end else begin
                  cmd_o.word_wr   = mlt_pkg::WR_NORM_STATE;
                  cmd_o.set_state = mlt_pkg::LS_CONTENDED;
                  cmd_o.status    = mlt_pkg::ST_WAIT;
                end
              end else if (stat_i.owner_match) begin
                if (stat_i.lk_type == mlt_pkg::LT_ERRORCHECK) begin
                  cmd_o.status = blocking ? mlt_pkg::ST_DEADLOCK : mlt_pkg::ST_BUSY;
                end else if (stat_i.cnt_full) begin
                  cmd_o.status = mlt_pkg::ST_OVERFLOW;
                end else begin
                  cmd_o.word_wr = mlt_pkg::WR_CNT_INC;
                  cmd_o.status  = mlt_pkg::ST_OK;
                end
              end else if (stat_i.lk_state == mlt_pkg::LS_UNLOCKED) begin
                cmd_o.word_wr   = mlt_pkg::WR_STATE;
                cmd_o.owner_wr  = mlt_pkg::OWN_SET;
                cmd_o.set_state = mlt_pkg::LS_LOCKED;
                cmd_o.status    = mlt_pkg::ST_OK;
              end else if (!blocking) begin
                cmd_o.status = mlt_pkg::ST_BUSY;
              end else begin
                // A held lock is marked contended; other held states stay.
                if (stat_i.lk_state == mlt_pkg::LS_LOCKED) begin
                  cmd_o.word_wr   = mlt_pkg::WR_STATE;
                  cmd_o.set_state = mlt_pkg::LS_CONTENDED;
                end
                cmd_o.status = mlt_pkg::ST_WAIT;
              end
            end
            mlt_pkg::OP_UNLOCK: begin
              if (stat_i.lk_type == mlt_pkg::LT_DEAD) begin
                cmd_o.status = mlt_pkg::ST_INVALID;
              end else if (stat_i.lk_type == mlt_pkg::LT_NORMAL) begin
                cmd_o.word_wr   = mlt_pkg::WR_NORM_STATE;
                cmd_o.set_state = mlt_pkg::LS_UNLOCKED;
                cmd_o.wake      = (stat_i.lk_state == mlt_pkg::LS_CONTENDED);
                cmd_o.status    = mlt_pkg::ST_OK;
              end else if (!stat_i.owner_match) begin
                cmd_o.status = mlt_pkg::ST_NOT_OWNER;
              end else if (!stat_i.cnt_zero) begin
                cmd_o.word_wr = mlt_pkg::WR_CNT_DEC;
                cmd_o.status  = mlt_pkg::ST_OK;
              end else begin
                cmd_o.word_wr   = mlt_pkg::WR_STATE;
                cmd_o.owner_wr  = mlt_pkg::OWN_CLEAR;
                cmd_o.set_state = mlt_pkg::LS_UNLOCKED;
                cmd_o.wake      = (stat_i.lk_state == mlt_pkg::LS_CONTENDED);
                cmd_o.status    = mlt_pkg::ST_OK;
              end
            end
            mlt_pkg::OP_DESTROY: begin
              if (stat_i.lk_state == mlt_pkg::LS_UNLOCKED) begin
                cmd_o.word_wr = mlt_pkg::WR_DESTROY;
                cmd_o.status  = mlt_pkg::ST_OK;
              end else begin
                cmd_o.status = mlt_pkg::ST_BUSY;
              end
            end
            default: begin
              cmd_o.status = mlt_pkg::ST_INVALID;
            end
          endcase
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

### src/mlt_datapath.sv
// mlt_datapath: lock table registers, request latch and result register.
// Depends on mlt_pkg; commanded by mlt_ctrl.
module mlt_datapath #(
  parameter int NUM_LOCKS    = mlt_pkg::NUM_LOCKS_DEF,
  parameter int COUNTER_BITS = mlt_pkg::COUNTER_BITS_DEF,
  parameter int TID_BITS     = mlt_pkg::TID_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [mlt_pkg::OP_W-1:0]       operation_i,
  input  logic [mlt_pkg::INDEX_W-1:0]    lock_index_i,
  input  logic [mlt_pkg::THREAD_W-1:0]   thread_id_i,
  input  logic [mlt_pkg::MTYPE_W-1:0]    mutex_type_i,
  input  logic                           process_shared_i,
  input  mlt_pkg::cmd_t                  cmd_i,
  output mlt_pkg::lock_stat_t            stat_o,
  output logic                           done_o,
  output logic [mlt_pkg::STATUS_W-1:0]   status_o,
  output logic                           wake_one_o
);

  // Only the entries that the index field can reach are built.
  localparam int DEPTH     = (NUM_LOCKS < mlt_pkg::ADDR_LOCKS) ? NUM_LOCKS
                                                                : mlt_pkg::ADDR_LOCKS;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_MAX_I = (1 << COUNTER_BITS) - 1;
  localparam int WORD_W    = mlt_pkg::WORD_W;

  logic [WORD_W-1:0]   table_word_q  [DEPTH];
  logic [TID_BITS-1:0] table_owner_q [DEPTH];

  logic                        in_range;
  logic [IDX_W-1:0]            idx;
  logic [TID_BITS-1:0]         tid;

  logic [mlt_pkg::OP_W-1:0]    req_op_q;
  logic [IDX_W-1:0]            req_idx_q;
  logic                        req_in_range_q;
  logic [TID_BITS-1:0]         req_tid_q;
  logic [mlt_pkg::MTYPE_W-1:0] req_mtype_q;
  logic                        req_shared_q;
  logic [WORD_W-1:0]           rd_word_q;
  logic [TID_BITS-1:0]         rd_owner_q;

  logic [WORD_W-1:0]           word_d;
  logic [TID_BITS-1:0]         owner_d;
  logic [mlt_pkg::CNT_FIELD_W-1:0] cnt;
  logic                        wr_en;

  logic                         done_q;
  logic [mlt_pkg::STATUS_W-1:0] status_q;
  logic                         wake_q;

  assign in_range = (32'(lock_index_i) < 32'(NUM_LOCKS));
  assign idx      = lock_index_i[IDX_W-1:0];
  assign tid      = TID_BITS'(thread_id_i);

  // Request latch and registered read of the addressed entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_op_q       <= operation_i;
      req_idx_q      <= idx;
      req_in_range_q <= in_range;
      req_tid_q      <= tid;
      req_mtype_q    <= mutex_type_i;
      req_shared_q   <= process_shared_i;
      rd_word_q      <= in_range ? table_word_q[idx] : '0;
      rd_owner_q     <= in_range ? table_owner_q[idx] : '0;
    end
  end

  assign cnt = rd_word_q[mlt_pkg::CNT_LSB +: mlt_pkg::CNT_FIELD_W];

  always_comb begin
    stat_o             = '0;
    stat_o.in_range    = req_in_range_q;
    stat_o.op          = req_op_q;
    stat_o.init_bad    = (req_mtype_q == mlt_pkg::LT_DEAD);
    stat_o.lk_type     = rd_word_q[WORD_W-1 -: mlt_pkg::MTYPE_W];
    stat_o.lk_state    = rd_word_q[1:0];
    stat_o.owner_match = (req_tid_q == rd_owner_q);
    stat_o.cnt_full    = (cnt >= CNT_MAX_I[mlt_pkg::CNT_FIELD_W-1:0]);
    stat_o.cnt_zero    = (cnt == '0);
  end

  always_comb begin
    word_d = rd_word_q;
    unique case (cmd_i.word_wr)
      mlt_pkg::WR_NONE: word_d = rd_word_q;
      mlt_pkg::WR_INIT: begin
        if (req_mtype_q == mlt_pkg::LT_DEAD) begin
          word_d = '0;
        end else begin
          word_d = {req_mtype_q, req_shared_q, 13'd0};
        end
      end
      mlt_pkg::WR_NORM_STATE: begin
        word_d = {2'b00, rd_word_q[mlt_pkg::SHARED_BIT], 11'd0, cmd_i.set_state};
      end
      mlt_pkg::WR_STATE:   word_d = {rd_word_q[WORD_W-1:2], cmd_i.set_state};
      mlt_pkg::WR_CNT_INC: word_d = rd_word_q + mlt_pkg::CNT_ONE;
      mlt_pkg::WR_CNT_DEC: word_d = rd_word_q - mlt_pkg::CNT_ONE;
      mlt_pkg::WR_DESTROY: word_d = mlt_pkg::W_DESTROYED;
      default:             word_d = rd_word_q;
    endcase
  end

  always_comb begin
    owner_d = rd_owner_q;
    unique case (cmd_i.owner_wr)
      mlt_pkg::OWN_KEEP:  owner_d = rd_owner_q;
      mlt_pkg::OWN_SET:   owner_d = req_tid_q;
      mlt_pkg::OWN_CLEAR: owner_d = '0;
      default:            owner_d = rd_owner_q;
    endcase
  end

  // Unchanged entries are written back as read, which is harmless.
  assign wr_en = cmd_i.done && req_in_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        table_word_q[i]  <= '0;
        table_owner_q[i] <= '0;
      end
    end else if (wr_en) begin
      table_word_q[req_idx_q]  <= word_d;
      table_owner_q[req_idx_q] <= owner_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      status_q <= cmd_i.status;
      wake_q   <= cmd_i.wake;
    end
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign wake_one_o = wake_q;

endmodule

### src/mutex_lock_table.sv
// mutex_lock_table: top level of a bank of hardware mutexes.
// Depends on mlt_pkg, mlt_ctrl and mlt_datapath.
//
//   Channel   Handshake          Payload ports
//   --------  -----------------  ----------------------------------------------
//   request   start / busy       operation_i, lock_index_i, thread_id_i,
//                                mutex_type_i, process_shared_i
//   result    done_o (strobe)    status_o, wake_one_o
//
// A request transaction is taken at a rising edge with start high and busy low.
// At the accepting edge the addressed lock entry is read into registers; then
// the S_EXEC state decides the operation and writes the entry back, so busy
// is high for one cycle after each accept and blocks new requests meanwhile.
// The result strobe done_o is high for exactly one cycle, the cycle after the
// update, and the receiver cannot stall it; a request taken in that same cycle
// already sees the updated entry.
// Reset (rst_ni low, asynchronous) clears every lock word and owner to zero,
// which is a normal, private, unlocked lock without owner, and idles the
// controller. There is no clearing pass.
//
// Each lock keeps a 16-bit word (type, shared flag, recursion counter, state)
// and an owner id. Recursive locks count re-entry by the owner up to the
// counter limit; errorcheck locks refuse a self lock; a lock that cannot be
// taken by a blocking request is marked contended and answers wait, and an
// unlock that releases a contended lock raises wake_one_o. Destroy marks an
// unlocked lock dead until the next init.
module mutex_lock_table #(
  parameter int NUM_LOCKS    = mlt_pkg::NUM_LOCKS_DEF,
  parameter int COUNTER_BITS = mlt_pkg::COUNTER_BITS_DEF,
  parameter int TID_BITS     = mlt_pkg::TID_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [mlt_pkg::OP_W-1:0]       operation_i,
  input  logic [mlt_pkg::INDEX_W-1:0]    lock_index_i,
  input  logic [mlt_pkg::THREAD_W-1:0]   thread_id_i,
  input  logic [mlt_pkg::MTYPE_W-1:0]    mutex_type_i,
  input  logic                           process_shared_i,
  output logic                           done_o,
  output logic [mlt_pkg::STATUS_W-1:0]   status_o,
  output logic                           wake_one_o
);

  // Command and status buses between the controller and the datapath.
  mlt_pkg::cmd_t       cmd;
  mlt_pkg::lock_stat_t stat;

  mlt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  mlt_datapath #(
    .NUM_LOCKS    (NUM_LOCKS),
    .COUNTER_BITS (COUNTER_BITS),
    .TID_BITS     (TID_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .operation_i      (operation_i),
    .lock_index_i     (lock_index_i),
    .thread_id_i      (thread_id_i),
    .mutex_type_i     (mutex_type_i),
    .process_shared_i (process_shared_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .done_o           (done_o),
    .status_o         (status_o),
    .wake_one_o       (wake_one_o)
  );

`ifndef SYNTHESIS
  // An accepted transaction keeps the block busy for the update cycle.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transaction");

  // Busy does not stay high past the update.
  a_busy_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // Every accepted transaction yields its result after the S_EXEC state and the done register.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result strobe missing after an accepted transaction");

  // A result is only shown for a transaction that went through an update.
  a_result_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a preceding update cycle");

  // A wake is only raised by a successful unlock.
  a_wake_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && wake_one_o) |-> (status_o == mlt_pkg::ST_OK))
    else $error("wake raised with a status other than ok");
`endif

endmodule
